// ----- hw/rtl/crtp_pkg.sv -----
// Package: shared types and constants for the CRT reconstruct-and-pack block.
package crtp_pkg;

  localparam int RES_W     = 50;
  localparam int RESULT_W  = 209;
  localparam int WEIGHT_W  = 192;
  localparam int PROD_W    = RES_W + WEIGHT_W;   // 242
  localparam int SUM_W     = 256;
  localparam int WIN_LIMBS = 5;
  localparam int WIN_W     = 64 * WIN_LIMBS;
  localparam int LANES     = 4;

  localparam logic REG_COEF_BITS   = 1'b0;
  localparam logic REG_TOTAL_LIMBS = 1'b1;

  localparam logic [6:0]  COEF_BITS_RST   = 7'd88;
  localparam logic [31:0] TOTAL_LIMBS_RST = 32'd1;

  localparam logic [WEIGHT_W-1:0] WEIGHT [LANES] = '{
    {64'h00000000003ffcec, 64'h0c7bef8b3e76031f, 64'h000bffcec0000001},
    {64'h00000000003ffcf0, 64'h0c57afdd2e780315, 64'hf00bffcf00000001},
    {64'h00000000003ffd34, 64'h0a3bf3e2be9a028f, 64'h000bffd340000001},
    {64'h00000000003ffd50, 64'h0987b504cea80261, 64'hf00bffd500000001}
  };

  localparam logic [SUM_W-1:0] MOD_F =
    {64'h00000000000000ff, 64'hf080592e1f40c894, 64'hbc9747effd180592, 64'hf00fffc200000001};
  localparam logic [SUM_W-1:0] MOD_2F =
    {64'h00000000000001ff, 64'he100b25c3e819129, 64'h792e8fdffa300b25, 64'he01fff8400000002};

  typedef struct packed {
    logic [RES_W-1:0] residue_0;
    logic [RES_W-1:0] residue_1;
    logic [RES_W-1:0] residue_2;
    logic [RES_W-1:0] residue_3;
    logic             padding;
    logic             first;
  } in_item_t;

  typedef struct packed {
    logic [63:0] limb;
    logic        run_end;
    logic        final_limb;
  } out_item_t;

  typedef struct packed {
    logic padding;
    logic first;
  } flag_t;

endpackage

// ----- hw/rtl/crtp_lane.sv -----
// One lane: residue times its 192-bit CRT weight, two register stages.
module crtp_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [crtp_pkg::RES_W-1:0]    residue,
  input  logic [crtp_pkg::WEIGHT_W-1:0] weight,
  output logic [crtp_pkg::PROD_W-1:0]   prod
);
  import crtp_pkg::*;

  // 6 x 32-bit weight chunks times 2 x 25-bit residue chunks
  logic [56:0]         pp_r [2][6];
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   row [2];
  logic [191:0]        even_w [2];
  logic [191:0]        odd_w [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 6; i++) begin
          pp_r[j][i] <= 57'(weight[32*i +: 32] * residue[25*j +: 25]);
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      even_w[j] = {7'd0, pp_r[j][4], 7'd0, pp_r[j][2], 7'd0, pp_r[j][0]};
      odd_w[j]  = {7'd0, pp_r[j][5], 7'd0, pp_r[j][3], 7'd0, pp_r[j][1]};
      row[j]    = (PROD_W'(even_w[j]) + (PROD_W'(odd_w[j]) << 32)) << (25 * j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= row[0] + row[1];
    end
  end

  assign prod = prod_r;

endmodule

// ----- hw/rtl/crtp_merge.sv -----
// Merge: sum of lane products, then subtract 2f and f where nonnegative.
module crtp_merge (
  input  logic                          clk,
  input  logic                          en,
  input  logic [crtp_pkg::PROD_W-1:0]   prod [crtp_pkg::LANES],
  output logic [crtp_pkg::RESULT_W-1:0] value
);
  import crtp_pkg::*;

  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    red2_r;
  logic [RESULT_W-1:0] val_r;
  logic [SUM_W-1:0]    t2;
  logic [SUM_W-1:0]    t1;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
    end
  end

  assign t2 = sum_r - MOD_2F;
  always_ff @(posedge clk) begin
    if (en) begin
      red2_r <= t2[SUM_W-1] ? sum_r : t2;
    end
  end

  assign t1 = red2_r - MOD_F;
  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= t1[SUM_W-1] ? red2_r[RESULT_W-1:0] : t1[RESULT_W-1:0];
    end
  end

  assign value = val_r;

endmodule

// ----- hw/rtl/crtp_pack.sv -----
// Pack: window accumulation, limb emission and the two-entry output queue.
module crtp_pack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [crtp_pkg::RESULT_W-1:0] value,
  input  crtp_pkg::flag_t               flags,
  input  logic [6:0]                    coef_bits,
  input  logic [31:0]                   total_limbs,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_stall,
  output crtp_pkg::out_item_t           out_item
);
  import crtp_pkg::*;

  logic [WIN_W-1:0] win_r, win_nxt;
  logic [5:0]       off_r, off_nxt;
  logic [31:0]      em_r, em_nxt;
  logic             fin_r, fin_nxt;
  logic [1:0]       pcnt_r, pcnt_nxt;
  out_item_t        p0_r, p0_nxt, p1_r, p1_nxt;

  logic [WIN_W-1:0] win_c, val_sh, sum;
  logic [5:0]       off_c;
  logic [31:0]      em_c, rem;
  logic             fin_c, act, out_take;
  logic [7:0]       pos;
  logic [1:0]       cnt, n;
  out_item_t        e0, e1;

  assign out_take = (pcnt_r != 2'd0) && !out_stall;
  assign take     = (pcnt_r == 2'd0) || ((pcnt_r == 2'd1) && !out_stall);

  always_comb begin
    win_c  = flags.first ? '0 : win_r;
    off_c  = flags.first ? '0 : off_r;
    em_c   = flags.first ? '0 : em_r;
    fin_c  = flags.first ? 1'b0 : fin_r;
    act    = !fin_c && (em_c < total_limbs);
    val_sh = (flags.padding ? '0 : WIN_W'(value)) << off_c;
    sum    = win_c + val_sh;
    pos    = 8'(off_c) + 8'(coef_bits);
    cnt    = pos[7:6];
    rem    = total_limbs - em_c;
    if (cnt == 2'd0) begin
      n = 2'd0;
    end else if (cnt == 2'd1 || rem == 32'd1) begin
      n = 2'd1;
    end else begin
      n = 2'd2;
    end
    if (!act) begin
      n = 2'd0;
    end
    e0.limb       = sum[63:0];
    e0.run_end    = (n == 2'd1);
    e0.final_limb = (rem == 32'd1);
    e1.limb       = sum[127:64];
    e1.run_end    = 1'b1;
    e1.final_limb = (rem == 32'd2);

    win_nxt = win_r;
    off_nxt = off_r;
    em_nxt  = em_r;
    fin_nxt = fin_r;
    if (load) begin
      if (act) begin
        case (cnt)
          2'd0:    win_nxt = sum;
          2'd1:    win_nxt = sum >> 64;
          default: win_nxt = sum >> 128;
        endcase
        off_nxt = pos[5:0];
        em_nxt  = em_c + 32'(n);
        fin_nxt = ((em_c + 32'(n)) >= total_limbs);
      end else begin
        win_nxt = win_c;
        off_nxt = off_c;
        em_nxt  = em_c;
        fin_nxt = 1'b1;
      end
    end

    pcnt_nxt = pcnt_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    if (load) begin
      pcnt_nxt = n;
      p0_nxt   = e0;
      p1_nxt   = e1;
    end else if (out_take) begin
      pcnt_nxt = pcnt_r - 2'd1;
      p0_nxt   = p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      off_r  <= '0;
      em_r   <= '0;
      fin_r  <= 1'b0;
      pcnt_r <= '0;
    end else begin
      win_r  <= win_nxt;
      off_r  <= off_nxt;
      em_r   <= em_nxt;
      fin_r  <= fin_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
  end

  assign out_valid = (pcnt_r != 2'd0);
  assign out_item  = p0_r;

endmodule

// ----- hw/rtl/crt_reconstruct_and_pack_top.sv -----
// Top level: CRT reconstruction lanes, merge pipeline and limb packer.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_item (four residues, padding, first)
//   out_    | output    | out_valid/out_stall| out_item (limb, run_end, final_limb)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Five register stages (two per lane, three in the merge) feed the packer,
// which drives out_valid from a register behind them. An item that yields two
// limbs holds the packer until its first limb has left, as out_ carries
// one limb at a time; otherwise one item per cycle while out_ is not stalled.
// rst_n is synchronous; it clears the window, counters and the output queue.
// A stall on out_ while a limb waits freezes the whole pipe and shows on
// in_stall the same cycle; two waiting limbs hold the pipe regardless of stall.
module crt_reconstruct_and_pack_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crtp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output crtp_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import crtp_pkg::*;

  logic [6:0]          coef_bits_r;
  logic [31:0]         total_limbs_r;
  logic                adv;
  logic [4:0]          vld_r;
  flag_t               flg_r [5];
  logic [RES_W-1:0]    res [LANES];
  logic [PROD_W-1:0]   prod [LANES];
  logic [RESULT_W-1:0] value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_bits_r   <= COEF_BITS_RST;
      total_limbs_r <= TOTAL_LIMBS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COEF_BITS:   coef_bits_r   <= cfg_data[6:0];
        REG_TOTAL_LIMBS: total_limbs_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe moves together whenever the packer can take an item
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flg_r[0] <= '{padding: in_item.padding, first: in_item.first};
      for (int s = 1; s < 5; s++) begin
        flg_r[s] <= flg_r[s-1];
      end
    end
  end

  assign res[0] = in_item.residue_0;
  assign res[1] = in_item.residue_1;
  assign res[2] = in_item.residue_2;
  assign res[3] = in_item.residue_3;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    crtp_lane u_lane (
      .clk     (clk),
      .en      (adv),
      .residue (res[k]),
      .weight  (WEIGHT[k]),
      .prod    (prod[k])
    );
  end

  crtp_merge u_merge (
    .clk   (clk),
    .en    (adv),
    .prod  (prod),
    .value (value)
  );

  crtp_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (adv && vld_r[4]),
    .value       (value),
    .flags       (flg_r[4]),
    .coef_bits   (coef_bits_r),
    .total_limbs (total_limbs_r),
    .take        (adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// ----- hw/rtl/crtp_checker.sv -----
// Checker on the top-level ports, bound to the top level.
module crtp_props (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input crtp_pkg::out_item_t out_item,
  input logic                cfg_ready
);
  import crtp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.final_limb |-> out_item.run_end)
    else $error("final limb not last of its item");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind crt_reconstruct_and_pack_top crtp_props u_crtp_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item),
  .cfg_ready (cfg_ready)
);

// ----- tb/crtp_checker.sv -----
// Checker: CRT value and limb packing prediction, compared against the out_ channel.
module crtp_checker
  import crtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [31:0] cfg_data,
  output int        fail_count,
  output int        limbs_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [255:0] CRT_W0 = {64'h0, 64'h00000000003ffcec,
                                     64'h0c7bef8b3e76031f, 64'h000bffcec0000001};
  localparam logic [255:0] CRT_W1 = {64'h0, 64'h00000000003ffcf0,
                                     64'h0c57afdd2e780315, 64'hf00bffcf00000001};
  localparam logic [255:0] CRT_W2 = {64'h0, 64'h00000000003ffd34,
                                     64'h0a3bf3e2be9a028f, 64'h000bffd340000001};
  localparam logic [255:0] CRT_W3 = {64'h0, 64'h00000000003ffd50,
                                     64'h0987b504cea80261, 64'hf00bffd500000001};
  localparam logic [255:0] PRIME_F = {64'h00000000000000ff, 64'hf080592e1f40c894,
                                      64'hbc9747effd180592, 64'hf00fffc200000001};
  localparam logic [255:0] PRIME_2F = {64'h00000000000001ff, 64'he100b25c3e819129,
                                       64'h792e8fdffa300b25, 64'he01fff8400000002};

  logic [6:0]   coef_bits;
  logic [31:0]  limb_target;
  logic [319:0] window;
  logic [5:0]   offset;
  logic [31:0]  limb_count;
  logic         done;
  out_item_t    limb_queue[$];

  assign limbs_pending = limb_queue.size();

  function automatic logic [255:0] crt_value(in_item_t it);
    logic [255:0] v;
    logic [255:0] t;
    v = 256'(it.residue_0) * CRT_W0 + 256'(it.residue_1) * CRT_W1
      + 256'(it.residue_2) * CRT_W2 + 256'(it.residue_3) * CRT_W3;
    t = v - PRIME_2F;
    if (!t[255]) v = t;
    t = v - PRIME_F;
    if (!t[255]) v = t;
    return v & ((256'd1 << 209) - 256'd1);
  endfunction

  task automatic pack_coefficient(in_item_t it);
    logic [255:0] v;
    logic [7:0]   span;
    int           n;
    out_item_t    o;
    if (it.first) begin
      window = '0; offset = '0; limb_count = '0; done = 1'b0;
    end
    if (done) return;
    if (limb_count >= limb_target) begin
      done = 1'b1;
      return;
    end
    v = it.padding ? 256'd0 : crt_value(it);
    window = window + (320'(v) << offset);
    span = 8'(offset) + 8'(coef_bits);
    offset = span[5:0];
    n = 0;
    for (int i = 0; i < int'(span[7:6]); i++) begin
      if (limb_count >= limb_target) break;
      limb_count = limb_count + 32'd1;
      o.limb = window[64*i +: 64];
      o.run_end = 1'b0;
      o.final_limb = (limb_count == limb_target);
      limb_queue.push_back(o);
      n++;
    end
    if (n > 0) limb_queue[limb_queue.size()-1].run_end = 1'b1;
    window = window >> (64 * int'(span[7:6]));
    if (limb_count >= limb_target) done = 1'b1;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      coef_bits = COEF_BITS_RST;
      limb_target = TOTAL_LIMBS_RST;
      window = '0; offset = '0; limb_count = '0; done = 1'b0;
      limb_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_COEF_BITS) coef_bits = cfg_data[6:0];
        else limb_target = cfg_data;
      end
      if (in_valid && !in_stall) pack_coefficient(in_item);
      if (out_valid && !out_stall) begin
        if (limb_queue.size() == 0) begin
          report("unexpected limb", out_item.limb, 64'h0);
        end else begin
          want = limb_queue.pop_front();
          if (out_item.limb !== want.limb) report("limb", out_item.limb, want.limb);
          if (out_item.run_end !== want.run_end)
            report("run_end", 64'(out_item.run_end), 64'(want.run_end));
          if (out_item.final_limb !== want.final_limb)
            report("final_limb", 64'(out_item.final_limb), 64'(want.final_limb));
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

// ----- tb/tb_crt_reconstruct_and_pack_top.sv -----
// Testbench top: stimulus, receiver stalls and verdict for the CRT pack block.
module tb_crt_reconstruct_and_pack_top;
  import crtp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          limbs_pending;

  // idle percentages per side; changed by phase
  int sender_idle_pct;
  int receiver_idle_pct;
  // request for a long receiver hold-off
  logic hold_req;

  crt_reconstruct_and_pack_top uut (.*);

  crtp_checker checker_i (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Receiver: random stalls, plus one long counted hold when asked so the
  // pipe fills and backs up onto in_stall.
  initial begin
    int   hold_left;
    logic held;
    hold_left = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        hold_left = 300;
        held = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // Residue with a bias toward the extremes; the full 50 bits are random so
  // unreduced values show up too.
  function automatic logic [49:0] pick_residue();
    int sel;
    sel = $urandom_range(15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return 50'({$urandom, $urandom});
  endfunction

  // Drive one item; in_valid stays high between back-to-back items.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  task automatic send_coef(logic [49:0] r0, logic [49:0] r1, logic [49:0] r2,
                           logic [49:0] r3, logic pad, logic start);
    in_item_t it;
    it.residue_0 = r0; it.residue_1 = r1; it.residue_2 = r2; it.residue_3 = r3;
    it.padding = pad; it.first = start;
    send_item(it);
  endtask

  // Register writes only once the block has drained.
  task automatic write_reg(logic idx, logic [31:0] val);
    in_valid <= 1'b0;
    while (limbs_pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [6:0] bits, logic [31:0] limbs);
    write_reg(REG_COEF_BITS, 32'(bits));
    write_reg(REG_TOTAL_LIMBS, limbs);
  endtask

  // One run: a first item, then random content; mostly well formed, with
  // random padding items and the odd restart in the middle.
  task automatic random_run(int count);
    send_coef(pick_residue(), pick_residue(), pick_residue(), pick_residue(),
              1'b0, 1'b1);
    for (int i = 1; i < count; i++) begin
      send_coef(pick_residue(), pick_residue(), pick_residue(), pick_residue(),
                ($urandom_range(9) == 0), ($urandom_range(39) == 0));
    end
  endtask

  initial begin
    logic [6:0]  bits_tab[8];
    logic [31:0] limbs_tab[8];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COEF_BITS;
    cfg_data = '0;
    hold_req = 1'b0;
    sender_idle_pct = 29;
    receiver_idle_pct = 49;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings (88 bits, one limb), then finished block
    // ignoring items until a new first.
    send_coef('1, '1, '1, '1, 1'b0, 1'b1);
    send_coef('0, '0, '0, '0, 1'b0, 1'b0);
    send_coef('0, '0, '0, '0, 1'b0, 1'b1);
    send_coef('1, '0, '1, '0, 1'b0, 1'b0);

    // Smallest legal spacing, extremes of residues, padding.
    configure(7'd64, 32'd6);
    send_coef('0, '0, '0, '0, 1'b0, 1'b1);
    send_coef('1, '1, '1, '1, 1'b0, 1'b0);
    send_coef(50'h1, 50'h0, 50'h0, 50'h0, 1'b0, 1'b0);
    send_coef('1, '1, '1, '1, 1'b1, 1'b0);
    send_coef('0, '0, '0, 50'h1, 1'b0, 1'b0);
    send_coef('1, '1, '1, '1, 1'b0, 1'b0);
    send_coef('1, '1, '1, '1, 1'b0, 1'b0);

    // Widest legal spacing: up to two limbs per item; restart mid run.
    configure(7'd96, 32'd7);
    send_coef('1, '1, '1, '1, 1'b0, 1'b1);
    send_coef('1, '0, '0, '1, 1'b0, 1'b0);
    send_coef('0, '1, '1, '0, 1'b0, 1'b1);
    send_coef('1, '1, '1, '1, 1'b0, 1'b0);
    send_coef('1, '1, '1, '1, 1'b0, 1'b0);

    // Zero limbs: finished at once. Then out-of-range spacings.
    configure(7'd96, 32'd0);
    send_coef('1, '1, '1, '1, 1'b0, 1'b1);
    configure(7'd0, 32'd3);
    send_coef('1, '1, '1, '1, 1'b0, 1'b1);
    send_coef('1, '1, '1, '1, 1'b0, 1'b0);
    configure(7'd127, 32'd5);
    send_coef('1, '1, '1, '1, 1'b0, 1'b1);
    send_coef('1, '1, '1, '1, 1'b0, 1'b0);
    send_coef('1, '1, '1, '1, 1'b0, 1'b0);

    // Random phases: mode by phase index (receiver-heavy idling, then
    // sender-heavy, then none).
    bits_tab  = '{7'd64, 7'd88, 7'd96, 7'd77, 7'd127, 7'd88, 7'd65, 7'd96};
    limbs_tab = '{32'd40, 32'd90, 32'hffffffff, 32'd25, 32'd60, 32'd1, 32'd100,
                  32'hffffffff};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        sender_idle_pct = 29; receiver_idle_pct = 49;
      end else if (ph < 6) begin
        sender_idle_pct = 49; receiver_idle_pct = 29;
      end else begin
        sender_idle_pct = 0; receiver_idle_pct = 0;
      end
      configure(bits_tab[ph], limbs_tab[ph]);
      if (ph == 6) hold_req <= 1'b1;
      random_run(60);
      hold_req <= 1'b0;
    end
    in_valid <= 1'b0;

    while (limbs_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_crt_reconstruct_and_pack_top OK");
    end else begin
      $display("tb_crt_reconstruct_and_pack_top NOT OK");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("tb_crt_reconstruct_and_pack_top NOT OK");
    $finish;
  end
endmodule
